FILE: design/fsam_pkg.sv
// Shared constants, types and control bundle for the factorized shift-and matcher.
package fsam_pkg;

    localparam int PATTERN_CAP = 31;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 5;
    localparam int MASK_W      = 32;
    localparam int K_W         = 5;
    localparam int CFG_W       = 64;
    localparam int REG_IDX_W   = 3;
    localparam int PAT_W       = PATTERN_CAP * BYTE_W;
    localparam int LAST_W      = PAT_W - 3 * CFG_W;

    localparam logic [REG_IDX_W-1:0] REG_PATTERN_A      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_B      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_C      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_D      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

    localparam logic [IDX_W-1:0] MIN_LENGTH    = 5'd2;
    localparam logic [IDX_W-1:0] LENGTH_RESET  = 5'd2;

    typedef enum logic [1:0] {
        FZ_CLEAR,
        FZ_SCAN,
        FZ_DONE
    } fz_state_t;

    typedef struct packed {
        logic               clear;
        logic               pbit_en;
        logic               link_en;
        logic [IDX_W-1:0]   pbit_idx;
        logic [IDX_W-1:0]   link_idx;
        logic [K_W-1:0]     bit_k;
        logic [IDX_W-1:0]   beg;
        logic [IDX_W-1:0]   cur;
        logic [BYTE_W-1:0]  cur_char;
    } fz_ctl_t;

endpackage

FILE: design/factorized_shift_and_matcher.sv
// Top level of the factorized shift-and matcher: configuration, cell row and automaton pipeline.
//
// Streams one text byte per clock unless held by output back-pressure or a rebuild, and
// returns one item per byte on the master side, set to 1 where a pattern occurrence ends;
// each byte passes a stage register and then the output register. The pattern (2 to
// MAX_PATTERN bytes) is factorized by a sequencer that handles one pattern position per
// cycle, staying on a position at each factor break, so s_axis_tready stays low while it
// runs after reset and from the last configuration write on (the write cycle included).
// s_axis_tuser[0] marks the first byte of a new text; that byte always reports no match.
module factorized_shift_and_matcher #(
    parameter int MAX_PATTERN = fsam_pkg::PATTERN_CAP
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [fsam_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [fsam_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [7:0] text_byte
    input  logic [0:0]                       s_axis_tuser,   // [0] new_text
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata    // [0] match_here, [7:1] zero
);
    import fsam_pkg::*;

    logic [PAT_W-1:0]        pattern_reg;
    logic [PAT_W-1:0]        pattern_next;
    logic [IDX_W-1:0]        length_reg;
    logic [IDX_W-1:0]        length_next;
    logic [IDX_W-1:0]        len_eff;
    logic [BYTE_W-1:0]       pat [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]  dup;
    logic [MASK_W-1:0]       cell_b [MAX_PATTERN];
    logic [MASK_W-1:0]       cell_l [MAX_PATTERN];
    fz_ctl_t                 fz_ctl;
    logic [MASK_W-1:0]       final_mask;
    logic                    fz_ready;

    logic [BYTE_W-1:0]       prev_reg;
    logic [BYTE_W-1:0]       prev_next;
    logic                    have_prev_reg;
    logic                    have_prev_next;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s1_first_reg;
    logic [MASK_W-1:0]       s1_bmask_reg;
    logic [MASK_W-1:0]       s1_lmask_reg;
    logic [MASK_W-1:0]       d_reg;
    logic [MASK_W-1:0]       d_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic                    match_reg;
    logic                    match_next;

    logic                    advance;
    logic                    accept;
    logic                    first_c;
    logic [MASK_W-1:0]       bmask_c;
    logic [MASK_W-1:0]       lmask_c;
    logic [MASK_W-1:0]       d_and;
    logic [MASK_W-1:0]       d_sum;

    always_comb
    begin
        pattern_next = pattern_reg;
        length_next  = length_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PATTERN_A:      pattern_next[CFG_W-1:0]         = cfg_wr_data;
                REG_PATTERN_B:      pattern_next[2*CFG_W-1:CFG_W]   = cfg_wr_data;
                REG_PATTERN_C:      pattern_next[3*CFG_W-1:2*CFG_W] = cfg_wr_data;
                REG_PATTERN_D:      pattern_next[PAT_W-1:3*CFG_W]   = cfg_wr_data[LAST_W-1:0];
                REG_PATTERN_LENGTH: length_next                     = cfg_wr_data[IDX_W-1:0];
                default:            length_next                     = length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= LENGTH_RESET;
        end
        else
        begin
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
        end
    end

    always_comb
    begin
        priority if (length_reg < MIN_LENGTH)
            len_eff = MIN_LENGTH;
        else if (32'(length_reg) > MAX_PATTERN)
            len_eff = IDX_W'(MAX_PATTERN);
        else
            len_eff = length_reg;
    end

    fsam_factorizer #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_factorizer (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_wr_en),
        .len        (len_eff),
        .pat        (pat),
        .dup        (dup),
        .ctl        (fz_ctl),
        .final_mask (final_mask),
        .ready      (fz_ready)
    );

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        logic [BYTE_W-1:0] left_char;

        assign pat[i] = pattern_reg[i*BYTE_W +: BYTE_W];

        if (i == 0)
        begin : g_first
            assign left_char = '0;
        end
        else
        begin : g_rest
            assign left_char = pattern_reg[(i-1)*BYTE_W +: BYTE_W];
        end

        fsam_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .pat_char  (pat[i]),
            .pat_prev  (left_char),
            .prev_byte (prev_reg),
            .text_byte (s_axis_tdata),
            .ctl       (fz_ctl),
            .b_mask    (cell_b[i]),
            .l_mask    (cell_l[i]),
            .dup       (dup[i])
        );
    end

    always_comb
    begin
        bmask_c = '0;
        lmask_c = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            bmask_c = bmask_c | cell_b[i];
            lmask_c = lmask_c | cell_l[i];
        end
    end

    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = advance && fz_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign first_c       = s_axis_tuser[0] || !have_prev_reg;

    assign d_and = (d_reg | MASK_W'(1)) & s1_bmask_reg;
    assign d_sum = d_and + (d_and & s1_lmask_reg);

    always_comb
    begin
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        s1_valid_next  = s1_valid_reg;
        d_next         = d_reg;
        m_valid_next   = m_valid_reg;
        match_next     = match_reg;
        if (accept)
        begin
            prev_next      = s_axis_tdata;
            have_prev_next = 1'b1;
        end
        if (advance)
        begin
            s1_valid_next = accept;
            m_valid_next  = s1_valid_reg;
            if (s1_valid_reg)
            begin
                d_next     = s1_first_reg ? '0 : d_sum;
                match_next = !s1_first_reg && ((d_sum & final_mask) != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            d_reg         <= '0;
            m_valid_reg   <= 1'b0;
            match_reg     <= 1'b0;
        end
        else
        begin
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            s1_valid_reg  <= s1_valid_next;
            d_reg         <= d_next;
            m_valid_reg   <= m_valid_next;
            match_reg     <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_first_reg <= first_c;
            s1_bmask_reg <= bmask_c;
            s1_lmask_reg <= lmask_c;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'b0, match_reg};

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !s_axis_tready)
        else $error("input taken during pattern rebuild");

    a_first_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_valid_reg && s1_first_reg) |=> (m_axis_tvalid && !m_axis_tdata[0]))
        else $error("first byte of a text reported a match");

    a_final_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        fz_ready |-> $onehot(final_mask))
        else $error("final mask not one-hot after rebuild");

    a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && m_axis_tvalid && !m_axis_tready) |=> s1_valid_reg)
        else $error("stage item lost during output stall");

endmodule

FILE: design/fsam_cell.sv
// One pattern position: factor bit and link bit storage, mask lookup and duplicate check.
module fsam_cell #(
    parameter int IDX = 0
) (
    input  logic                         clk,
    input  logic [fsam_pkg::BYTE_W-1:0]  pat_char,
    input  logic [fsam_pkg::BYTE_W-1:0]  pat_prev,
    input  logic [fsam_pkg::BYTE_W-1:0]  prev_byte,
    input  logic [fsam_pkg::BYTE_W-1:0]  text_byte,
    input  fsam_pkg::fz_ctl_t            ctl,
    output logic [fsam_pkg::MASK_W-1:0]  b_mask,
    output logic [fsam_pkg::MASK_W-1:0]  l_mask,
    output logic                         dup
);
    import fsam_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [MASK_W-1:0] pbits_reg;
    logic [MASK_W-1:0] pbits_next;
    logic [MASK_W-1:0] link_reg;
    logic [MASK_W-1:0] link_next;
    logic [MASK_W-1:0] bit_sel;

    assign bit_sel = MASK_W'(1) << ctl.bit_k;

    always_comb
    begin
        pbits_next = pbits_reg;
        link_next  = link_reg;
        if (ctl.clear)
        begin
            pbits_next = (IDX == 1) ? MASK_W'(1) : '0;
            link_next  = (IDX == 0) ? MASK_W'(1) : '0;
        end
        else
        begin
            if (ctl.pbit_en && (ctl.pbit_idx == MY_IDX))
                pbits_next = pbits_reg | bit_sel;
            if (ctl.link_en && (ctl.link_idx == MY_IDX))
                link_next = link_reg | bit_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        pbits_reg <= pbits_next;
        link_reg  <= link_next;
    end

    assign b_mask = ((IDX != 0) && (pat_prev == prev_byte) && (pat_char == text_byte))
                    ? pbits_reg : '0;
    assign l_mask = (pat_char == prev_byte) ? link_reg : '0;
    assign dup    = (MY_IDX >= ctl.beg) && (MY_IDX < ctl.cur) && (pat_char == ctl.cur_char);

endmodule

FILE: design/fsam_factorizer.sv
// Sequencer that splits the pattern into factors of distinct bytes, one position per cycle outside factor breaks.
module fsam_factorizer #(
    parameter int MAX_PATTERN = fsam_pkg::PATTERN_CAP
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         restart,
    input  logic [fsam_pkg::IDX_W-1:0]   len,
    input  logic [fsam_pkg::BYTE_W-1:0]  pat [MAX_PATTERN],
    input  logic [MAX_PATTERN-1:0]       dup,
    output fsam_pkg::fz_ctl_t            ctl,
    output logic [fsam_pkg::MASK_W-1:0]  final_mask,
    output logic                         ready
);
    import fsam_pkg::*;

    fz_state_t          state_reg;
    fz_state_t          state_next;
    logic [IDX_W-1:0]   cur_reg;
    logic [IDX_W-1:0]   cur_next;
    logic [IDX_W-1:0]   beg_reg;
    logic [IDX_W-1:0]   beg_next;
    logic [K_W-1:0]     k_reg;
    logic [K_W-1:0]     k_next;
    logic [MASK_W-1:0]  final_reg;
    logic [MASK_W-1:0]  final_next;
    logic [BYTE_W-1:0]  cur_char;
    logic               in_range;
    logic               any_dup;
    logic               long_tail;

    always_comb
    begin
        cur_char = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (cur_reg == IDX_W'(i))
                cur_char = pat[i];
        end
    end

    assign in_range  = cur_reg < len;
    assign any_dup   = |dup;
    assign long_tail = cur_reg > (beg_reg + IDX_W'(1));

    always_comb
    begin
        state_next = state_reg;
        priority if (restart)
            state_next = FZ_CLEAR;
        else
        begin
            unique case (state_reg)
                FZ_CLEAR: state_next = FZ_SCAN;
                FZ_SCAN:
                begin
                    if (!in_range)
                        state_next = FZ_DONE;
                end
                FZ_DONE:  state_next = FZ_DONE;
                default:  state_next = FZ_CLEAR;
            endcase
        end
    end

    always_comb
    begin
        ctl          = '0;
        ctl.bit_k    = k_reg;
        ctl.beg      = beg_reg;
        ctl.cur      = cur_reg;
        ctl.cur_char = cur_char;
        cur_next     = cur_reg;
        beg_next     = beg_reg;
        k_next       = k_reg;
        final_next   = final_reg;
        ready        = 1'b0;
        unique case (state_reg)
            FZ_CLEAR:
            begin
                ctl.clear = 1'b1;
                cur_next  = IDX_W'(1);
                beg_next  = IDX_W'(1);
                k_next    = K_W'(1);
            end
            FZ_SCAN:
            begin
                priority if (in_range && !any_dup)
                begin
                    ctl.pbit_en  = cur_reg > beg_reg;
                    ctl.pbit_idx = cur_reg;
                    cur_next     = cur_reg + IDX_W'(1);
                end
                else if (in_range)
                begin
                    ctl.pbit_en  = 1'b1;
                    ctl.pbit_idx = cur_reg;
                    ctl.link_en  = 1'b1;
                    ctl.link_idx = cur_reg - IDX_W'(1);
                    beg_next     = cur_reg;
                    k_next       = k_reg + K_W'(1);
                end
                else
                begin
                    ctl.link_en  = long_tail;
                    ctl.link_idx = cur_reg - IDX_W'(2);
                    final_next   = long_tail ? (MASK_W'(1) << (k_reg + K_W'(1)))
                                             : (MASK_W'(1) << k_reg);
                end
            end
            FZ_DONE:
            begin
                ready = !restart;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FZ_CLEAR;
            cur_reg   <= IDX_W'(1);
            beg_reg   <= IDX_W'(1);
            k_reg     <= K_W'(1);
            final_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            beg_reg   <= beg_next;
            k_reg     <= k_next;
            final_reg <= final_next;
        end
    end

    assign final_mask = final_reg;

endmodule

FILE: bench/fsam_match_checker.sv
// Checker for the factorized shift-and matcher: tracks the pattern registers, predicts every match flag and compares.
`timescale 1ns / 1ps
module fsam_match_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [fsam_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [fsam_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] text_byte
    input  logic [0:0]                     s_axis_tuser,   // [0] new_text
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [7:0]                     m_axis_tdata,   // [0] match_here, [7:1] zero
    output int                             mismatches,
    output int                             pending
);
    import fsam_pkg::*;

    localparam logic [CFG_W-1:0] LAST_WORD_KEEP = (64'd1 << LAST_W) - 64'd1;

    logic [CFG_W-1:0]  pattern_word [4];
    logic [IDX_W-1:0]  length_code;
    logic [BYTE_W-1:0] pattern_char [PATTERN_CAP];
    int                used_len;
    logic [MASK_W-1:0] factor_bits [PATTERN_CAP];
    logic [MASK_W-1:0] link_bits [PATTERN_CAP];
    logic [MASK_W-1:0] final_mask;
    logic [MASK_W-1:0] state_mask;
    logic [BYTE_W-1:0] last_byte;
    logic              last_byte_valid;
    logic              match_queue [$];
    int                result_count;

    function automatic void rebuild_tables();
        int i;
        int k;
        int beg;
        int fin;
        bit seen_char [256];
        used_len = int'(length_code);
        if (used_len < int'(MIN_LENGTH))
            used_len = int'(MIN_LENGTH);
        if (used_len > PATTERN_CAP)
            used_len = PATTERN_CAP;
        for (i = 0; i < PATTERN_CAP; i++)
        begin
            pattern_char[i] = pattern_word[i / 8][(i % 8) * BYTE_W +: BYTE_W];
            factor_bits[i]  = '0;
            link_bits[i]    = '0;
        end
        factor_bits[1] = 32'd1;
        link_bits[0]   = 32'd1;
        k = 1;
        beg = 1;
        fin = 1;
        final_mask = '0;
        while (k < MASK_W)
        begin
            foreach (seen_char[c])
                seen_char[c] = 1'b0;
            while (fin < used_len && !seen_char[pattern_char[fin]])
            begin
                seen_char[pattern_char[fin]] = 1'b1;
                fin++;
            end
            for (i = beg + 1; i < fin; i++)
                factor_bits[i] |= 32'd1 << k;
            if (fin < used_len)
            begin
                factor_bits[fin]   |= 32'd1 << k;
                link_bits[fin - 1] |= 32'd1 << k;
            end
            else
            begin
                final_mask = 32'd1 << k;
                if (fin > beg + 1)
                begin
                    link_bits[fin - 2] |= 32'd1 << k;
                    final_mask = final_mask << 1;
                end
                break;
            end
            beg = fin;
            k++;
        end
    endfunction

    function automatic logic predict_match(input logic [BYTE_W-1:0] text_byte,
                                           input logic new_text);
        logic [MASK_W-1:0] pair_sel;
        logic [MASK_W-1:0] link_sel;
        int i;
        if (new_text || !last_byte_valid)
        begin
            state_mask      = '0;
            last_byte       = text_byte;
            last_byte_valid = 1'b1;
            return 1'b0;
        end
        pair_sel = '0;
        link_sel = '0;
        for (i = 1; i < used_len; i++)
            if (pattern_char[i - 1] == last_byte && pattern_char[i] == text_byte)
                pair_sel |= factor_bits[i];
        for (i = 0; i + 1 < used_len; i++)
            if (pattern_char[i] == last_byte)
                link_sel |= link_bits[i];
        state_mask = (state_mask | 32'd1) & pair_sel;
        state_mask = state_mask + (state_mask & link_sel);
        last_byte  = text_byte;
        return (state_mask & final_mask) != '0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic want;
        if (!rst_n)
        begin
            foreach (pattern_word[w])
                pattern_word[w] = '0;
            length_code     = LENGTH_RESET;
            state_mask      = '0;
            last_byte       = '0;
            last_byte_valid = 1'b0;
            match_queue.delete();
            result_count    = 0;
            mismatches      = 0;
            pending         = 0;
            rebuild_tables();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_PATTERN_A, REG_PATTERN_B, REG_PATTERN_C:
                    begin
                        pattern_word[int'(cfg_index)] = cfg_wr_data;
                        rebuild_tables();
                    end
                    REG_PATTERN_D:
                    begin
                        pattern_word[3] = cfg_wr_data & LAST_WORD_KEEP;
                        rebuild_tables();
                    end
                    REG_PATTERN_LENGTH:
                    begin
                        length_code = cfg_wr_data[IDX_W-1:0];
                        rebuild_tables();
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                match_queue.push_back(predict_match(s_axis_tdata, s_axis_tuser[0]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_count++;
                if (match_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: none expected, got tdata=%h",
                                 result_count, m_axis_tdata);
                end
                else
                begin
                    want = match_queue.pop_front();
                    if (m_axis_tdata !== {7'b0, want})
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected tdata=%h, got tdata=%h",
                                     result_count, {7'b0, want}, m_axis_tdata);
                    end
                end
            end
            pending = match_queue.size();
        end
    end

endmodule

FILE: bench/factorized_shift_and_matcher_test.sv
// Testbench top for the factorized shift-and matcher: clock, reset, pattern setup, text stimulus and verdict.
`timescale 1ns / 1ps
module factorized_shift_and_matcher_test;
    import fsam_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
    localparam int TEXT_GOAL   = 1100;
    localparam int CALM_AFTER  = 950;
    localparam int SINK_HOLD   = 150;
    localparam int QUIET_LIMIT = 2000;

    typedef enum int {
        PAT_SAME,
        PAT_DISTINCT,
        PAT_FEW,
        PAT_ANY
    } pattern_style_t;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_wr_data   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [7:0] text_byte
    logic [0:0]           s_axis_tuser  = '0;   // [0] new_text
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // [0] match_here, [7:1] zero
    int                   mismatches;
    int                   pending;

    logic [7:0]           pattern_text [PATTERN_CAP];
    int                   pattern_len   = 2;
    int                   text_items    = 0;
    int                   src_idle_pct  = 0;
    int                   sink_idle_pct = 0;
    logic                 sink_hold_req = 1'b0;
    int                   quiet_cycles  = 0;

    factorized_shift_and_matcher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fsam_match_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic did_hold;
        int gap;
        did_hold = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_req && !did_hold)
            begin
                did_hold = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD) @(negedge clk);
            end
            if (sink_idle_pct == 0 || $urandom_range(99) >= sink_idle_pct)
                m_axis_tready <= 1'b1;
            else
            begin
                gap = $urandom_range(1, 17);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= value;
        @(posedge clk);
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic offer_byte(input logic [7:0] text_byte, input logic new_text);
        int gap;
        @(negedge clk);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            gap = $urandom_range(1, 17);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= text_byte;
        s_axis_tuser  <= new_text;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic program_pattern(input pattern_style_t style, input logic [IDX_W-1:0] code);
        logic [7:0]       pick [32];
        logic [CFG_W-1:0] word [4];
        logic [CFG_W-1:0] len_word;
        logic [7:0]       base;
        int i;
        base = 8'($urandom);
        for (i = 0; i < 32; i++)
        begin
            case (style)
                PAT_SAME:     pick[i] = base;
                PAT_DISTINCT: pick[i] = base + 8'(i);
                PAT_FEW:      pick[i] = base + 8'($urandom_range(0, 2));
                default:      pick[i] = 8'($urandom);
            endcase
        end
        pick[31] = 8'($urandom);
        for (i = 0; i < 32; i++)
        begin
            word[i / 8][(i % 8) * 8 +: 8] = pick[i];
            if (i < PATTERN_CAP)
                pattern_text[i] = pick[i];
        end
        len_word = {$urandom, $urandom};
        len_word[IDX_W-1:0] = code;
        pattern_len = (code < MIN_LENGTH) ? int'(MIN_LENGTH) : int'(code);
        write_reg(REG_PATTERN_A, word[0]);
        write_reg(REG_PATTERN_B, word[1]);
        write_reg(REG_PATTERN_C, word[2]);
        write_reg(REG_PATTERN_D, word[3]);
        write_reg(REG_PATTERN_LENGTH, len_word);
        if ($urandom_range(3) == 0)
            write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), {$urandom, $urandom});
        end_writes();
    endtask

    task automatic stream_text(input int count);
        logic [7:0] plan [$];
        logic       new_text;
        int i;
        int j;
        int n;
        int roll;
        for (i = 0; i < count; i++)
        begin
            if (plan.size() == 0)
            begin
                roll = $urandom_range(99);
                if (roll < 50)
                begin
                    for (j = 0; j < pattern_len; j++)
                        plan.push_back(pattern_text[j]);
                    if ($urandom_range(4) == 0)
                        plan[$urandom_range(pattern_len - 1)] = 8'($urandom);
                end
                else if (roll < 70)
                begin
                    n = $urandom_range(1, pattern_len);
                    for (j = 0; j < n; j++)
                        plan.push_back(pattern_text[j]);
                end
                else if (roll < 90)
                begin
                    n = $urandom_range(1, 3);
                    for (j = 0; j < n; j++)
                        plan.push_back(pattern_text[$urandom_range(pattern_len - 1)]);
                end
                else
                    plan.push_back(8'($urandom));
            end
            new_text = (i == 0) ? ($urandom_range(9) < 7) : ($urandom_range(49) == 0);
            offer_byte(plan.pop_front(), new_text);
        end
        text_items += count;
    endtask

    initial
    begin
        pattern_style_t style;
        logic [IDX_W-1:0] code;
        int phase;
        int count;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // pattern of two zero bytes after reset; first item has no new_text flag
        offer_byte(8'h00, 1'b0);
        offer_byte(8'h00, 1'b0);
        offer_byte(8'h00, 1'b0);
        offer_byte(8'hFF, 1'b0);
        offer_byte(8'h00, 1'b0);
        offer_byte(8'h00, 1'b0);
        offer_byte(8'h80, 1'b1);
        offer_byte(8'h00, 1'b0);
        offer_byte(8'h00, 1'b0);
        drain();

        write_reg(REG_PATTERN_A, {32'($urandom), 16'($urandom), 16'h4241});
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        write_reg(REG_SPARE_FIRST, '1);
        end_writes();
        offer_byte(8'h41, 1'b1);
        offer_byte(8'h42, 1'b0);
        offer_byte(8'h41, 1'b0);
        offer_byte(8'h42, 1'b0);
        offer_byte(8'h42, 1'b0);
        offer_byte(8'h41, 1'b0);
        drain();

        write_reg(REG_PATTERN_LENGTH, 64'd1);
        end_writes();
        offer_byte(8'h42, 1'b0);
        offer_byte(8'h41, 1'b0);
        offer_byte(8'h42, 1'b0);
        drain();

        phase = 0;
        while (text_items < TEXT_GOAL)
        begin
            case (phase)
                0:
                begin
                    style = PAT_SAME;
                    code  = 5'd31;
                end
                1:
                begin
                    style = PAT_DISTINCT;
                    code  = 5'd31;
                end
                2:
                begin
                    style = PAT_FEW;
                    code  = 5'd31;
                end
                3:
                begin
                    style = PAT_ANY;
                    code  = 5'd0;
                end
                4:
                begin
                    style = PAT_FEW;
                    code  = 5'd1;
                end
                5:
                begin
                    style = PAT_SAME;
                    code  = 5'd2;
                end
                default:
                begin
                    style = pattern_style_t'($urandom_range(PAT_SAME, PAT_ANY));
                    code  = 5'($urandom);
                end
            endcase
            program_pattern(style, code);
            if (text_items > CALM_AFTER)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            else
            begin
                src_idle_pct  = 15 * $urandom_range(0, 2);
                sink_idle_pct = 15 * $urandom_range(0, 2);
            end
            count = (code > 5'd20) ? $urandom_range(60, 90) : $urandom_range(25, 70);
            if (phase == 3)
            begin
                src_idle_pct  = 0;
                sink_hold_req = 1'b1;
                count         = 80;
            end
            stream_text(count);
            drain();
            phase++;
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
